/* design/ppfc_pkg.sv */
// Shared types, constants and component packing helpers for the pixel format converter.
`default_nettype none

package ppfc_pkg;

  // Field and datapath widths
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COMP_W  = 16;
  localparam int unsigned SUM_W   = 18;  // r+g+b, also holds 3*max
  localparam int unsigned PROD_W  = 34;  // sum * alpha
  localparam int unsigned CPROD_W = 32;  // colour * alpha

  // Component width codes
  localparam logic [2:0] WCODE_1  = 3'd0;
  localparam logic [2:0] WCODE_2  = 3'd1;
  localparam logic [2:0] WCODE_4  = 3'd2;
  localparam logic [2:0] WCODE_8  = 3'd3;
  localparam logic [2:0] WCODE_16 = 3'd4;

  // Register indexes (byte address bit 2)
  localparam logic REG_WIDTH_CODE = 1'b0;
  localparam logic REG_LAYOUT     = 1'b1;

  typedef enum logic [1:0] {
    LAYOUT_GRAY       = 2'd0,
    LAYOUT_GRAY_ALPHA = 2'd1,
    LAYOUT_RGB        = 2'd2,
    LAYOUT_RGBA       = 2'd3
  } layout_t;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  // Fields that ride alongside the divider pipeline
  typedef struct packed {
    mode_t               mode;
    layout_t             req;
    logic [WORD_W-1:0]   word;
    logic [COMP_W-1:0]   alpha_val;
  } side_t;

  // One classified beat held in the queue
  typedef struct packed {
    side_t               side;
    logic [PROD_W-1:0]   prod_gray;
    logic [CPROD_W-1:0]  prod_red;
    logic [CPROD_W-1:0]  prod_green;
    logic [CPROD_W-1:0]  prod_blue;
  } job_t;

  // Component maximum 2^W-1; codes above four mean 16 bits
  function automatic logic [COMP_W-1:0] comp_max(input logic [2:0] code);
    logic [COMP_W-1:0] m;
    case (code)
      WCODE_1: m = 16'h0001;
      WCODE_2: m = 16'h0003;
      WCODE_4: m = 16'h000F;
      WCODE_8: m = 16'h00FF;
      default: m = 16'hFFFF;
    endcase
    return m;
  endfunction

  // Bit offset of component idx
  function automatic logic [5:0] comp_shift(input logic [2:0] code, input logic [1:0] idx);
    logic [5:0] s;
    case (code)
      WCODE_1: s = {4'b0, idx};
      WCODE_2: s = {3'b0, idx, 1'b0};
      WCODE_4: s = {2'b0, idx, 2'b0};
      WCODE_8: s = {1'b0, idx, 3'b0};
      default: s = {idx, 4'b0};
    endcase
    return s;
  endfunction

  function automatic logic [COMP_W-1:0] get_comp(input logic [WORD_W-1:0] word,
                                                 input logic [2:0] code,
                                                 input logic [1:0] idx);
    logic [WORD_W-1:0] sh;
    sh = word >> comp_shift(code, idx);
    return sh[COMP_W-1:0] & comp_max(code);
  endfunction

  // Replace component idx, keeping every other bit
  function automatic logic [WORD_W-1:0] put_comp(input logic [WORD_W-1:0] word,
                                                 input logic [2:0] code,
                                                 input logic [1:0] idx,
                                                 input logic [COMP_W-1:0] v);
    logic [WORD_W-1:0] mask;
    logic [5:0]        s;
    s    = comp_shift(code, idx);
    mask = {{(WORD_W-COMP_W){1'b0}}, comp_max(code)} << s;
    return (word & ~mask) | (({{(WORD_W-COMP_W){1'b0}}, v} << s) & mask);
  endfunction

endpackage

`default_nettype wire

/* design/ppfc_front.sv */
// Front end: unpacks or gathers components, picks alpha factors and forms the products.
`default_nettype none

module ppfc_front (
  input  wire logic [2:0]                width_code,
  input  wire logic [1:0]                stored_layout,
  input  wire logic                      mode,
  input  wire logic [1:0]                request_layout,
  input  wire logic [ppfc_pkg::WORD_W-1:0] pixel_word,
  input  wire logic [ppfc_pkg::COMP_W-1:0] red,
  input  wire logic [ppfc_pkg::COMP_W-1:0] green,
  input  wire logic [ppfc_pkg::COMP_W-1:0] blue,
  input  wire logic [ppfc_pkg::COMP_W-1:0] alpha,
  output ppfc_pkg::job_t                 job
);
  import ppfc_pkg::*;

  logic [COMP_W-1:0] mx;
  logic [COMP_W-1:0] r, g, b, a_mul, a_out;
  logic [COMP_W-1:0] a_gray, a_col;
  logic              has_a, fold_gray, fold_col;
  logic [SUM_W-1:0]  sum;

  // Classify the beat and select operands
  always_comb begin
    mx = comp_max(width_code);
    if (mode_t'(mode) == MODE_READ) begin
      has_a = stored_layout[0];
      if (stored_layout[1] == 1'b0) begin
        r     = get_comp(pixel_word, width_code, 2'd0);
        g     = r;
        b     = r;
        a_mul = has_a ? get_comp(pixel_word, width_code, 2'd1) : mx;
      end else begin
        r     = get_comp(pixel_word, width_code, 2'd0);
        g     = get_comp(pixel_word, width_code, 2'd1);
        b     = get_comp(pixel_word, width_code, 2'd2);
        a_mul = has_a ? get_comp(pixel_word, width_code, 2'd3) : mx;
      end
      a_out     = a_mul;
      fold_gray = has_a && (layout_t'(request_layout) == LAYOUT_GRAY);
      fold_col  = has_a && (layout_t'(request_layout) == LAYOUT_RGB);
    end else begin
      has_a = request_layout[0];
      if (request_layout[1] == 1'b0) begin
        r = red;
        g = red;
        b = red;
      end else begin
        r = red;
        g = green;
        b = blue;
      end
      a_mul     = alpha & mx;
      a_out     = has_a ? alpha : mx;
      fold_gray = has_a && (layout_t'(stored_layout) == LAYOUT_GRAY);
      fold_col  = has_a && (layout_t'(stored_layout) == LAYOUT_RGB);
    end
    // Factor max leaves the value as is once divided by max
    a_gray = fold_gray ? a_mul : mx;
    a_col  = fold_col  ? a_mul : mx;
    sum    = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
  end

  // Products; the divide by max (or 3*max) happens in the back end
  always_comb begin
    job.side.mode      = mode_t'(mode);
    job.side.req       = layout_t'(request_layout);
    job.side.word      = pixel_word;
    job.side.alpha_val = a_out;
    job.prod_gray      = PROD_W'(sum) * PROD_W'(a_gray);
    job.prod_red       = CPROD_W'(r) * CPROD_W'(a_col);
    job.prod_green     = CPROD_W'(g) * CPROD_W'(a_col);
    job.prod_blue      = CPROD_W'(b) * CPROD_W'(a_col);
  end

endmodule

`default_nettype wire

/* design/ppfc_queue.sv */
// Short FIFO between the front end and the divider back end.
`default_nettype none

module ppfc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ppfc_pkg::job_t wr_job,
  input  wire logic           pop,
  output ppfc_pkg::job_t      head,
  output logic                not_empty,
  output logic                full
);
  import ppfc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign head      = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/ppfc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, 16-bit quotient.
`default_nettype none

module ppfc_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [ppfc_pkg::PROD_W-1:0] dividend,
  input  wire logic [ppfc_pkg::SUM_W-1:0]  divisor,
  output logic [ppfc_pkg::COMP_W-1:0]      quotient
);
  import ppfc_pkg::*;

  logic [PROD_W-1:0] rem [1:COMP_W];
  logic [SUM_W-1:0]  dvs [1:COMP_W];
  logic [COMP_W-1:0] quo [1:COMP_W];

  for (genvar s = 1; s <= COMP_W; s++) begin : g_stage
    localparam int unsigned BIT = COMP_W - s;
    logic [PROD_W-1:0] rem_prev, trial;
    logic [SUM_W-1:0]  dvs_prev;
    logic [COMP_W-1:0] quo_prev;
    logic              take;

    if (s == 1) begin : g_first
      assign rem_prev = dividend;
      assign dvs_prev = divisor;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem[s-1];
      assign dvs_prev = dvs[s-1];
      assign quo_prev = quo[s-1];
    end

    // Trial subtract of the shifted divisor
    assign trial = PROD_W'(dvs_prev) << BIT;
    assign take  = (rem_prev >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? rem_prev - trial : rem_prev;
        dvs[s] <= dvs_prev;
        quo[s] <= quo_prev | (COMP_W'(take) << BIT);
      end
    end
  end

  assign quotient = quo[COMP_W];

endmodule

`default_nettype wire

/* design/ppfc_back.sv */
// Back end: divides the products, packs or selects the results, holds the output register.
`default_nettype none

module ppfc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [2:0]                  width_code,
  input  wire logic [1:0]                  stored_layout,
  input  wire ppfc_pkg::job_t              head,
  input  wire logic                        head_valid,
  output logic                             pop,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [ppfc_pkg::WORD_W-1:0]      new_pixel_word,
  output logic [ppfc_pkg::COMP_W-1:0]      out_red,
  output logic [ppfc_pkg::COMP_W-1:0]      out_green,
  output logic [ppfc_pkg::COMP_W-1:0]      out_blue,
  output logic [ppfc_pkg::COMP_W-1:0]      out_alpha
);
  import ppfc_pkg::*;

  localparam int unsigned STAGES = COMP_W;

  logic              en;
  logic [COMP_W-1:0] mx;
  logic [SUM_W-1:0]  div_col, div_gray;
  logic [COMP_W-1:0] q_gray, q_red, q_green, q_blue;
  logic [STAGES:1]   vld;
  side_t             side [1:STAGES];
  side_t             last;

  logic [WORD_W-1:0] word_next;
  logic [COMP_W-1:0] red_next, green_next, blue_next, alpha_next;

  // Whole pipeline advances whenever the output register can take a beat
  assign en  = !out_valid || !out_stall;
  assign pop = en && head_valid;

  assign mx       = comp_max(width_code);
  assign div_col  = SUM_W'(mx);
  assign div_gray = (SUM_W'(mx) << 1) + SUM_W'(mx);

  ppfc_div u_div_gray (
    .clk(clk), .en(en), .dividend(head.prod_gray), .divisor(div_gray), .quotient(q_gray)
  );
  ppfc_div u_div_red (
    .clk(clk), .en(en), .dividend(PROD_W'(head.prod_red)), .divisor(div_col),
    .quotient(q_red)
  );
  ppfc_div u_div_green (
    .clk(clk), .en(en), .dividend(PROD_W'(head.prod_green)), .divisor(div_col),
    .quotient(q_green)
  );
  ppfc_div u_div_blue (
    .clk(clk), .en(en), .dividend(PROD_W'(head.prod_blue)), .divisor(div_col),
    .quotient(q_blue)
  );

  // Valid bits alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-1:1], head_valid};
    end
  end

  // Side fields alongside the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= head.side;
      for (int s = 2; s <= STAGES; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  assign last = side[STAGES];

  // Result selection and packing
  always_comb begin
    word_next  = last.word;
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    alpha_next = '0;
    if (last.mode == MODE_READ) begin
      case (last.req)
        LAYOUT_GRAY: begin
          red_next = q_gray;
        end
        LAYOUT_GRAY_ALPHA: begin
          red_next   = q_gray;
          alpha_next = last.alpha_val;
        end
        LAYOUT_RGB: begin
          red_next   = q_red;
          green_next = q_green;
          blue_next  = q_blue;
        end
        default: begin
          red_next   = q_red;
          green_next = q_green;
          blue_next  = q_blue;
          alpha_next = last.alpha_val;
        end
      endcase
    end else begin
      case (layout_t'(stored_layout))
        LAYOUT_GRAY: begin
          word_next = put_comp(last.word, width_code, 2'd0, q_gray);
        end
        LAYOUT_GRAY_ALPHA: begin
          word_next = put_comp(last.word, width_code, 2'd0, q_gray);
          word_next = put_comp(word_next, width_code, 2'd1, last.alpha_val);
        end
        LAYOUT_RGB: begin
          word_next = put_comp(last.word, width_code, 2'd0, q_red);
          word_next = put_comp(word_next, width_code, 2'd1, q_green);
          word_next = put_comp(word_next, width_code, 2'd2, q_blue);
        end
        default: begin
          word_next = put_comp(last.word, width_code, 2'd0, q_red);
          word_next = put_comp(word_next, width_code, 2'd1, q_green);
          word_next = put_comp(word_next, width_code, 2'd2, q_blue);
          word_next = put_comp(word_next, width_code, 2'd3, last.alpha_val);
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[STAGES]) begin
      new_pixel_word <= word_next;
      out_red        <= red_next;
      out_green      <= green_next;
      out_blue       <= blue_next;
      out_alpha      <= alpha_next;
    end
  end

endmodule

`default_nettype wire

/* design/packed_pixel_format_converter.sv */
// An accepted beat passes through the queue, the divider stages and the output register.
// Throughput: one pixel per cycle unless stalled; the 16-stage divider pipeline
//   (one quotient bit a stage) and the output register advance together, one beat a cycle.
// Reset (synchronous, rst high): queue empty, pipeline and output invalid,
//   component_width_code = 3 (8 bits), stored_layout = 3 (RGBA).
`default_nettype none

module packed_pixel_format_converter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [1:0]                    request_layout,
  input  wire logic [ppfc_pkg::WORD_W-1:0]   pixel_word,
  input  wire logic [ppfc_pkg::COMP_W-1:0]   red,
  input  wire logic [ppfc_pkg::COMP_W-1:0]   green,
  input  wire logic [ppfc_pkg::COMP_W-1:0]   blue,
  input  wire logic [ppfc_pkg::COMP_W-1:0]   alpha,
  // Output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ppfc_pkg::WORD_W-1:0]        new_pixel_word,
  output logic [ppfc_pkg::COMP_W-1:0]        out_red,
  output logic [ppfc_pkg::COMP_W-1:0]        out_green,
  output logic [ppfc_pkg::COMP_W-1:0]        out_blue,
  output logic [ppfc_pkg::COMP_W-1:0]        out_alpha
);
  import ppfc_pkg::*;

  logic [2:0] component_width_code;
  logic [1:0] stored_layout;
  logic       cfg_wr;
  job_t       front_job, head_job;
  logic       push, pop, q_not_empty, q_full;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      component_width_code <= WCODE_8;
      stored_layout        <= LAYOUT_RGBA;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH_CODE) begin
        component_width_code <= pwdata[2:0];
      end else begin
        stored_layout <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WIDTH_CODE) begin
      prdata[2:0] = component_width_code;
    end else begin
      prdata[1:0] = stored_layout;
    end
  end

  // Front end
  ppfc_front u_front (
    .width_code     (component_width_code),
    .stored_layout  (stored_layout),
    .mode           (mode),
    .request_layout (request_layout),
    .pixel_word     (pixel_word),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .job            (front_job)
  );

  // Queue between the two halves
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  ppfc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (front_job),
    .pop       (pop),
    .head      (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back end
  ppfc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .width_code     (component_width_code),
    .stored_layout  (stored_layout),
    .head           (head_job),
    .head_valid     (q_not_empty),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .new_pixel_word (new_pixel_word),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha)
  );

endmodule

`default_nettype wire

/* design/ppfc_checker.sv */
// Port-level checks for the pixel format converter, bound to the top level.
`default_nettype none

module ppfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] new_pixel_word,
  input wire logic [15:0] out_red,
  input wire logic [15:0] out_green,
  input wire logic [15:0] out_blue,
  input wire logic [15:0] out_alpha
);

  // Reset leaves no result beat behind
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid after reset");

  // Reset empties the queue, so input is taken at once
  a_reset_frees_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // A stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(new_pixel_word) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_alpha))
    else $error("stalled result beat changed");

  // Width code reads back what was written
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2]
      |=> paddr[2] || (prdata[2:0] == $past(pwdata[2:0])))
    else $error("width code readback mismatch");

endmodule

bind packed_pixel_format_converter ppfc_checker u_ppfc_checker (.*);

`default_nettype wire

/* tb/packed_pixel_format_converter_tb.sv */
// Self-checking testbench for the packed pixel format converter: directed, random and backpressure tests.
module packed_pixel_format_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned PIPE_LATENCY = 17;
  // out-of-range width code, behaves as 16 bits
  localparam logic [2:0] WCODE_BEYOND = 3'd7;

  typedef struct {
    mode_t       mode;
    layout_t     req;
    logic [63:0] word;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pixel_req_t;

  typedef struct {
    logic [63:0] word;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pixel_res_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [1:0]  request_layout;
  logic [63:0] pixel_word;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] alpha;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] new_pixel_word;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;

  // Local copy of the block's registers
  logic [2:0]   cfg_width_code;
  layout_t      cfg_layout;

  pixel_res_t   pending_pixels[$];
  int unsigned  mismatches;
  int unsigned  cycle_count;

  // Sender and receiver pacing
  int unsigned  gap_max;
  int unsigned  burst_left;
  stall_style_t stall_style;
  bit           hold_request;

  packed_pixel_format_converter DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .request_layout(request_layout), .pixel_word(pixel_word),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_pixel_word(new_pixel_word),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("packed_pixel_format_converter_tb: FAIL");
    $finish;
  end

  // Component idx of a packed word
  function automatic logic [63:0] field_at(logic [63:0] word, int unsigned idx,
                                           int unsigned bits, logic [63:0] mx);
    return (word >> (idx * bits)) & mx;
  endfunction

  // Replace component idx, truncating v to the component width
  function automatic logic [63:0] with_field(logic [63:0] word, int unsigned idx,
                                             logic [63:0] v, int unsigned bits,
                                             logic [63:0] mx);
    logic [63:0] mask;
    mask = mx << (idx * bits);
    return (word & ~mask) | ((v << (idx * bits)) & mask);
  endfunction

  // Expected result of one pixel beat under the current register settings
  function automatic pixel_res_t convert_pixel(pixel_req_t p);
    pixel_res_t  res;
    int unsigned bits;
    logic [63:0] mx, r, g, b, a, am, sum, mean, word;
    bit          has_a;
    bits = (cfg_width_code > WCODE_16) ? 16 : (1 << cfg_width_code);
    mx   = (64'd1 << bits) - 64'd1;
    word = p.word;
    res.word  = word;
    res.red   = '0;
    res.green = '0;
    res.blue  = '0;
    res.alpha = '0;
    if (p.mode == MODE_READ) begin
      has_a = cfg_layout[0];
      if (cfg_layout == LAYOUT_GRAY || cfg_layout == LAYOUT_GRAY_ALPHA) begin
        r = field_at(word, 0, bits, mx);
        g = r;
        b = r;
        a = has_a ? field_at(word, 1, bits, mx) : mx;
      end else begin
        r = field_at(word, 0, bits, mx);
        g = field_at(word, 1, bits, mx);
        b = field_at(word, 2, bits, mx);
        a = has_a ? field_at(word, 3, bits, mx) : mx;
      end
      sum  = r + g + b;
      mean = sum / 3;
      case (p.req)
        LAYOUT_GRAY: begin
          res.red = 16'(has_a ? (sum * a) / (3 * mx) : mean);
        end
        LAYOUT_GRAY_ALPHA: begin
          res.red   = 16'(mean);
          res.alpha = 16'(a);
        end
        LAYOUT_RGB: begin
          res.red   = 16'(has_a ? (r * a) / mx : r);
          res.green = 16'(has_a ? (g * a) / mx : g);
          res.blue  = 16'(has_a ? (b * a) / mx : b);
        end
        default: begin
          res.red   = 16'(r);
          res.green = 16'(g);
          res.blue  = 16'(b);
          res.alpha = 16'(a);
        end
      endcase
      return res;
    end
    // write: convert the given values into the stored layout
    has_a = p.req[0];
    if (p.req == LAYOUT_GRAY || p.req == LAYOUT_GRAY_ALPHA) begin
      r = 64'(p.red);
      g = r;
      b = r;
    end else begin
      r = 64'(p.red);
      g = 64'(p.green);
      b = 64'(p.blue);
    end
    a    = 64'(p.alpha);
    am   = a & mx;
    sum  = r + g + b;
    mean = sum / 3;
    case (cfg_layout)
      LAYOUT_GRAY: begin
        word = with_field(word, 0, has_a ? (sum * am) / (3 * mx) : mean, bits, mx);
      end
      LAYOUT_GRAY_ALPHA: begin
        word = with_field(word, 0, mean, bits, mx);
        word = with_field(word, 1, has_a ? a : mx, bits, mx);
      end
      LAYOUT_RGB: begin
        word = with_field(word, 0, has_a ? (r * am) / mx : r, bits, mx);
        word = with_field(word, 1, has_a ? (g * am) / mx : g, bits, mx);
        word = with_field(word, 2, has_a ? (b * am) / mx : b, bits, mx);
      end
      default: begin
        word = with_field(word, 0, r, bits, mx);
        word = with_field(word, 1, g, bits, mx);
        word = with_field(word, 2, b, bits, mx);
        word = with_field(word, 3, has_a ? a : mx, bits, mx);
      end
    endcase
    res.word = word;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on each accepted input beat, check each accepted output beat
  always @(posedge clk) begin
    pixel_req_t p;
    pixel_res_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        p.mode  = mode_t'(mode);
        p.req   = layout_t'(request_layout);
        p.word  = pixel_word;
        p.red   = red;
        p.green = green;
        p.blue  = blue;
        p.alpha = alpha;
        pending_pixels = {pending_pixels, convert_pixel(p)};
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $error("result beat with no pixel pending");
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("new_pixel_word", want.word, new_pixel_word);
          check_field("out_red", 64'(want.red), 64'(out_red));
          check_field("out_green", 64'(want.green), 64'(out_green));
          check_field("out_blue", 64'(want.blue), 64'(out_blue));
          check_field("out_alpha", 64'(want.alpha), 64'(out_alpha));
        end
      end
    end
  end

  // Receiver: stall pattern, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned tick;
    hold_left = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_style)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= ((tick % 7) < 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Offer one beat and hold it until accepted; gaps fall between bursts
  task automatic send_pixel(input pixel_req_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    mode           <= p.mode;
    request_layout <= p.req;
    pixel_word     <= p.word;
    red            <= p.red;
    green          <= p.green;
    blue           <= p.blue;
    alpha          <= p.alpha;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Stop offering and wait for every pending result
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_WIDTH_CODE) cfg_width_code = value[2:0];
    else cfg_layout = layout_t'(value[1:0]);
  endtask

  task automatic set_format(input logic [2:0] code, input layout_t lay);
    write_register(REG_WIDTH_CODE, 32'(code));
    write_register(REG_LAYOUT, 32'(lay));
  endtask

  function automatic pixel_req_t make_pixel(mode_t m, layout_t req, logic [63:0] word,
                                            logic [15:0] r, logic [15:0] g,
                                            logic [15:0] b, logic [15:0] a);
    pixel_req_t p;
    p.mode  = m;
    p.req   = req;
    p.word  = word;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  // Level biased towards zero, the component maximum and full scale
  function automatic logic [15:0] pick_level(logic [63:0] mx);
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return mx[15:0];
      2:       return 16'hFFFF;
      3, 4:    return 16'($urandom_range(0, 32'(mx)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t  p;
    logic [63:0] mx;
    mx = (cfg_width_code > WCODE_16) ? 64'hFFFF : (64'd1 << (1 << cfg_width_code)) - 64'd1;
    p.mode = mode_t'($urandom_range(0, 1));
    p.req  = layout_t'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       p.word = '0;
      1:       p.word = '1;
      default: p.word = {$urandom, $urandom};
    endcase
    p.red   = pick_level(mx);
    p.green = pick_level(mx);
    p.blue  = pick_level(mx);
    p.alpha = pick_level(mx);
    return p;
  endfunction

  // Reset settings (8-bit RGBA): every mode and request, before any register write
  task automatic test_reset_settings();
    for (int m = 0; m < 2; m++) begin
      for (int q = 0; q < 4; q++) begin
        send_pixel(make_pixel(mode_t'(m), layout_t'(q), 64'hFEDC_BA98_7654_3210,
                              16'hFFFF, 16'h0000, 16'h8000, 16'h00FF));
      end
    end
    drain_pixels();
  endtask

  // Extreme widths, each stored layout, zero and full alpha, out-of-range width code
  task automatic test_directed_cases();
    set_format(WCODE_1, LAYOUT_GRAY);
    send_pixel(make_pixel(MODE_READ, LAYOUT_GRAY, '1, 16'h0, 16'h0, 16'h0, 16'h0));
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_GRAY_ALPHA, 64'h0, 16'hFFFF, 16'h0, 16'h0,
                          16'h0000));
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_GRAY, '1, 16'h0000, 16'h0, 16'h0, 16'hFFFF));
    drain_pixels();

    set_format(WCODE_16, LAYOUT_GRAY_ALPHA);
    send_pixel(make_pixel(MODE_READ, LAYOUT_GRAY, '1, 16'h0, 16'h0, 16'h0, 16'h0));
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_GRAY_ALPHA, 64'h0, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF));
    send_pixel(make_pixel(MODE_READ, LAYOUT_RGBA, 64'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_RGBA, '1, 16'h1234, 16'h0, 16'h0, 16'h0000));
    drain_pixels();

    set_format(WCODE_BEYOND, LAYOUT_RGB);
    send_pixel(make_pixel(MODE_READ, LAYOUT_RGB, '1, 16'h0, 16'h0, 16'h0, 16'h0));
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_RGBA, 64'h0, 16'hFFFF, 16'h8001, 16'h7FFE,
                          16'h1234));
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_RGB, 64'hA5A5_5A5A_F0F0_0F0F, 16'hFFFF,
                          16'h0000, 16'hFFFF, 16'hFFFF));
    drain_pixels();

    set_format(WCODE_4, LAYOUT_RGBA);
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_RGBA, '1, 16'h00F5, 16'h000F, 16'h0000,
                          16'h00F5));
    send_pixel(make_pixel(MODE_READ, LAYOUT_GRAY_ALPHA, 64'h0000_0000_0000_F0FF, 16'h0,
                          16'h0, 16'h0, 16'h0));
    send_pixel(make_pixel(MODE_WRITE, LAYOUT_GRAY, 64'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0));
    drain_pixels();
  endtask

  // Random beats across all width codes and layouts with changing pacing
  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 8) set_format(3'(phase), layout_t'(phase % 4));
      else set_format(3'($urandom_range(0, 7)), layout_t'($urandom_range(0, 3)));
      case (phase % 3)
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 8;
      endcase
      stall_style = stall_style_t'(phase % 4);
      for (int n = 0; n < 75; n++) send_pixel(random_pixel());
      drain_pixels();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering: fills the block
  task automatic test_output_holdoff();
    set_format(WCODE_8, LAYOUT_RGBA);
    gap_max = 0;
    stall_style = STALL_NONE;
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) send_pixel(random_pixel());
    drain_pixels();
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    mode           = MODE_READ;
    request_layout = LAYOUT_GRAY;
    pixel_word     = '0;
    red            = '0;
    green          = '0;
    blue           = '0;
    alpha          = '0;
    mismatches     = 0;
    gap_max        = 4;
    burst_left     = 0;
    stall_style    = STALL_LIGHT;
    hold_request   = 1'b0;
    cfg_width_code = WCODE_8;
    cfg_layout     = LAYOUT_RGBA;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_directed_cases();
    test_random_settings();
    test_output_holdoff();

    // Catch any stray beat after the last expected one
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("packed_pixel_format_converter_tb: PASS");
    else
      $display("packed_pixel_format_converter_tb: FAIL");
    $finish;
  end

endmodule

/* packed_pixel_format_converter.f */
design/ppfc_pkg.sv
design/ppfc_front.sv
design/ppfc_queue.sv
design/ppfc_div.sv
design/ppfc_back.sv
design/packed_pixel_format_converter.sv
design/ppfc_checker.sv
tb/packed_pixel_format_converter_tb.sv
